[hdl/hcalu_pkg.sv]
// ----------------------------------------------------------------------------
// hcalu_pkg
// Operation codes, flag layout and operand/result types shared by the ALU
// datapath and its pipeline wrapper.
// ----------------------------------------------------------------------------
package hcalu_pkg;

  // operation codes
  typedef enum logic [4:0] {
    MODE_ADD   = 5'd0,
    MODE_ADC   = 5'd1,
    MODE_SUB   = 5'd2,
    MODE_SBC   = 5'd3,
    MODE_AND   = 5'd4,
    MODE_XOR   = 5'd5,
    MODE_OR    = 5'd6,
    MODE_CP    = 5'd7,
    MODE_INC   = 5'd8,
    MODE_DEC   = 5'd9,
    MODE_RLC   = 5'd10,
    MODE_RRC   = 5'd11,
    MODE_RL    = 5'd12,
    MODE_RR    = 5'd13,
    MODE_SLA   = 5'd14,
    MODE_SRA   = 5'd15,
    MODE_SWAP  = 5'd16,
    MODE_SRL   = 5'd17,
    MODE_BIT   = 5'd18,
    MODE_RES   = 5'd19,
    MODE_SET   = 5'd20,
    MODE_DAA   = 5'd21,
    MODE_ADD16 = 5'd22,
    MODE_INC16 = 5'd23,
    MODE_DEC16 = 5'd24
  } mode_t;

  // flag bit positions in the 4-bit flag word
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // decimal adjust constants
  localparam logic [7:0] DAA_ADJ_HI  = 8'h60;
  localparam logic [7:0] DAA_ADJ_LO  = 8'h06;
  localparam logic [7:0] DAA_MAX_BCD = 8'h99;
  localparam logic [3:0] DAA_MAX_DIG = 4'h9;

  // one operation as presented to the datapath
  typedef struct packed {
    logic [4:0]  mode;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic        accum_form;
    logic [3:0]  flags_in;
  } alu_op_t;

  // one result as produced by the datapath
  typedef struct packed {
    logic [15:0] result;
    logic [3:0]  flags_out;
    logic        write_result;
  } alu_res_t;

endpackage

[hdl/handheld_cpu_alu_with_flags.sv]
// ----------------------------------------------------------------------------
// handheld_cpu_alu_with_flags
// Registered 8/16-bit ALU with flag generation for a small handheld CPU.
// ----------------------------------------------------------------------------
// One operation per clock while in_stall is low: an accepted item is captured in
// the input register, passes the combinational ALU logic and lands in the result
// register, which drives out_valid, and a new item may be transferred in every
// cycle that in_stall is low. The input register and the result register form a
// two-entry pipeline; in_stall rises only when both hold an item and the result is
// stalled. Flags use bit3 Z, bit2 N, bit1 H, bit0 C.
module handheld_cpu_alu_with_flags
  import hcalu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  in_mode,
  input  logic [15:0] in_operand_a,
  input  logic [15:0] in_operand_b,
  input  logic [2:0]  in_bit_index,
  input  logic        in_accum_form,
  input  logic [3:0]  in_flags_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_result,
  output logic [3:0]  out_flags_out,
  output logic        out_write_result
);

  alu_op_t  op_r;
  alu_op_t  op_nxt;
  logic     op_valid_r;
  alu_res_t res_r;
  alu_res_t res_nxt;
  logic     res_valid_r;
  logic     res_load;
  logic     op_load;

  // pipeline advance
  assign res_load = !res_valid_r || !out_stall;
  assign op_load  = !op_valid_r || res_load;
  assign in_stall = !op_load;

  assign op_nxt = '{mode: in_mode, operand_a: in_operand_a, operand_b: in_operand_b,
                    bit_index: in_bit_index, accum_form: in_accum_form,
                    flags_in: in_flags_in};

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_valid_r <= 1'b0;
    end else if (op_load) begin
      op_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op_load && in_valid) begin
      op_r <= op_nxt;
    end
  end

  // alu datapath
  hcalu_core u_core (
    .op  (op_r),
    .res (res_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (res_load) begin
      res_valid_r <= op_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load && op_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = res_valid_r;
  assign out_result       = res_r.result;
  assign out_flags_out    = res_r.flags_out;
  assign out_write_result = res_r.write_result;

  // input is held back only with both stages full and the output stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (op_valid_r && res_valid_r && out_stall))
    else $error("input stalled without a full pipeline");

  // a transfer into a free pipeline is followed by a valid result in the result register
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !res_valid_r) |=> ##1 res_valid_r)
    else $error("accepted item did not reach the result register");

  // byte operations other than res and set leave the high result byte clear
  a_byte_high: assert property (@(posedge clk) disable iff (!rst_n)
    (op_valid_r && res_load && (op_r.mode < MODE_ADD16) && (op_r.mode != MODE_RES)
     && (op_r.mode != MODE_SET)) |=> (res_r.result[15:8] == 8'd0))
    else $error("byte operation produced a nonzero high byte");

endmodule

[hdl/hcalu_core.sv]
// ----------------------------------------------------------------------------
// hcalu_core
// Single-pass ALU datapath: byte arithmetic and logic, rotates and shifts,
// bit operations, decimal adjust and the 16-bit add/inc/dec, with flags.
// ----------------------------------------------------------------------------
module hcalu_core
  import hcalu_pkg::*;
(
  input  alu_op_t  op,
  output alu_res_t res
);

  logic [7:0]  a;
  logic [7:0]  b;
  logic [3:0]  f;
  logic        cin;
  logic        ci_add;
  logic        ci_sub;
  logic [8:0]  add_s;
  logic [4:0]  add_h;
  logic [8:0]  sub_d;
  logic [4:0]  sub_h;
  logic [7:0]  inc_r;
  logic [7:0]  dec_r;
  logic [7:0]  sh_r;
  logic        sh_c;
  logic        sh_rot;
  logic [7:0]  bit_mask;
  logic        daa_lo;
  logic        daa_hi;
  logic [7:0]  daa_corr;
  logic [7:0]  daa_r;
  logic [16:0] w_s;
  logic [12:0] w_h;
  mode_t       mode;

  assign mode = mode_t'(op.mode);
  assign a    = op.operand_a[7:0];
  assign b    = op.operand_b[7:0];
  assign f    = op.flags_in;
  assign cin  = f[FLAG_C];

  // add and subtract with nibble carry
  assign ci_add = (mode == MODE_ADC) ? cin : 1'b0;
  assign ci_sub = (mode == MODE_SBC) ? cin : 1'b0;
  assign add_s  = {1'b0, a} + {1'b0, b} + {8'd0, ci_add};
  assign add_h  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, ci_add};
  assign sub_d  = {1'b0, a} - {1'b0, b} - {8'd0, ci_sub};
  assign sub_h  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, ci_sub};
  assign inc_r  = a + 8'd1;
  assign dec_r  = a - 8'd1;

  // rotates, shifts and swap
  always_comb begin
    sh_r = a;
    sh_c = 1'b0;
    case (mode)
      MODE_RLC: begin
        sh_c = a[7];
        sh_r = {a[6:0], a[7]};
      end
      MODE_RRC: begin
        sh_c = a[0];
        sh_r = {a[0], a[7:1]};
      end
      MODE_RL: begin
        sh_c = a[7];
        sh_r = {a[6:0], cin};
      end
      MODE_RR: begin
        sh_c = a[0];
        sh_r = {cin, a[7:1]};
      end
      MODE_SLA: begin
        sh_c = a[7];
        sh_r = {a[6:0], 1'b0};
      end
      MODE_SRA: begin
        sh_c = a[0];
        sh_r = {a[7], a[7:1]};
      end
      MODE_SWAP: begin
        sh_r = {a[3:0], a[7:4]};
      end
      MODE_SRL: begin
        sh_c = a[0];
        sh_r = {1'b0, a[7:1]};
      end
      default: begin
        sh_r = a;
        sh_c = 1'b0;
      end
    endcase
  end

  // accumulator-form rotates force z low
  assign sh_rot = (mode == MODE_RLC) || (mode == MODE_RRC) ||
                  (mode == MODE_RL)  || (mode == MODE_RR);

  assign bit_mask = 8'd1 << op.bit_index;

  // decimal adjust correction
  assign daa_lo   = f[FLAG_H] || (!f[FLAG_N] && (a[3:0] > DAA_MAX_DIG));
  assign daa_hi   = cin || (!f[FLAG_N] && (a > DAA_MAX_BCD));
  assign daa_corr = (daa_hi ? DAA_ADJ_HI : 8'd0) | (daa_lo ? DAA_ADJ_LO : 8'd0);
  assign daa_r    = f[FLAG_N] ? (a - daa_corr) : (a + daa_corr);

  // 16-bit add with carries out of bits 11 and 15
  assign w_s = {1'b0, op.operand_a} + {1'b0, op.operand_b};
  assign w_h = {1'b0, op.operand_a[11:0]} + {1'b0, op.operand_b[11:0]};

  // result and flag select
  always_comb begin
    res.result       = op.operand_a;
    res.flags_out    = f;
    res.write_result = 1'b1;
    unique case (mode)
      MODE_ADD, MODE_ADC: begin
        res.result    = {8'd0, add_s[7:0]};
        res.flags_out = {~|add_s[7:0], 1'b0, add_h[4], add_s[8]};
      end
      MODE_SUB, MODE_SBC, MODE_CP: begin
        res.result       = {8'd0, sub_d[7:0]};
        res.flags_out    = {~|sub_d[7:0], 1'b1, sub_h[4], sub_d[8]};
        res.write_result = (mode != MODE_CP);
      end
      MODE_AND: begin
        res.result    = {8'd0, a & b};
        res.flags_out = {~|(a & b), 1'b0, 1'b1, 1'b0};
      end
      MODE_XOR: begin
        res.result    = {8'd0, a ^ b};
        res.flags_out = {~|(a ^ b), 3'b000};
      end
      MODE_OR: begin
        res.result    = {8'd0, a | b};
        res.flags_out = {~|(a | b), 3'b000};
      end
      MODE_INC: begin
        res.result    = {8'd0, inc_r};
        res.flags_out = {~|inc_r, 1'b0, &a[3:0], cin};
      end
      MODE_DEC: begin
        res.result    = {8'd0, dec_r};
        res.flags_out = {~|dec_r, 1'b1, ~|a[3:0], cin};
      end
      MODE_RLC, MODE_RRC, MODE_RL, MODE_RR,
      MODE_SLA, MODE_SRA, MODE_SWAP, MODE_SRL: begin
        res.result    = {8'd0, sh_r};
        res.flags_out = {(sh_rot && op.accum_form) ? 1'b0 : ~|sh_r, 2'b00, sh_c};
      end
      MODE_BIT: begin
        res.result       = {8'd0, a};
        res.flags_out    = {~|(a & bit_mask), 1'b0, 1'b1, cin};
        res.write_result = 1'b0;
      end
      MODE_RES: begin
        res.result = {8'd0, a & ~bit_mask};
      end
      MODE_SET: begin
        res.result = {8'd0, a | bit_mask};
      end
      MODE_DAA: begin
        res.result    = {8'd0, daa_r};
        res.flags_out = {~|daa_r, f[FLAG_N], 1'b0, daa_hi};
      end
      MODE_ADD16: begin
        res.result    = w_s[15:0];
        res.flags_out = {f[FLAG_Z], 1'b0, w_h[12], w_s[16]};
      end
      MODE_INC16: begin
        res.result = op.operand_a + 16'd1;
      end
      MODE_DEC16: begin
        res.result = op.operand_a - 16'd1;
      end
      default: begin
        // unused codes pass the operand through with no write
        res.result       = op.operand_a;
        res.flags_out    = f;
        res.write_result = 1'b0;
      end
    endcase
  end

endmodule

[dv/handheld_cpu_alu_with_flags_tb.sv]
// ----------------------------------------------------------------------------
// handheld_cpu_alu_with_flags_tb
// Self-checking bench for the registered handheld CPU ALU. Directed corner
// operations come first, then about 750 random operations in bursts with
// random gaps. The receiver stalls in changing patterns, including long
// hold-offs that fill the pipeline. An in-bench flag and result predictor
// checks every result transfer in order.
// ----------------------------------------------------------------------------
module handheld_cpu_alu_with_flags_tb
  import hcalu_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NUM_RANDOM_OPS = 750;
  localparam int          MAX_REPORTS    = 10;
  localparam logic [4:0]  MODE_SPARE_LO  = 5'd25;
  localparam logic [4:0]  MODE_SPARE_HI  = 5'd31;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_kind_t;

  // expected result store with flag predictor
  class alu_result_checker;
    alu_res_t expected_results[$];
    int       failures;
    int       mismatches;

    function new();
      failures   = 0;
      mismatches = 0;
    endfunction

    function alu_res_t predict(alu_op_t op);
      logic [7:0]  a, b, r8, adj;
      logic [15:0] r16;
      logic [8:0]  s9, d9;
      logic [4:0]  s5, d5;
      logic [16:0] s17;
      logic [12:0] s13;
      logic [3:0]  f, fo;
      logic        ci, co, neg, wr, wide;
      alu_res_t    res;
      a    = op.operand_a[7:0];
      b    = op.operand_b[7:0];
      f    = op.flags_in;
      fo   = f;
      wr   = 1'b1;
      wide = 1'b0;
      co   = 1'b0;
      r8   = a;
      r16  = op.operand_a;
      case (op.mode)
        MODE_ADD, MODE_ADC: begin
          ci = (op.mode == MODE_ADC) ? f[FLAG_C] : 1'b0;
          s9 = {1'b0, a} + {1'b0, b} + {8'd0, ci};
          s5 = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, ci};
          r8 = s9[7:0];
          fo = '0;
          fo[FLAG_Z] = (r8 == 8'h00);
          fo[FLAG_H] = s5[4];
          fo[FLAG_C] = s9[8];
        end
        MODE_SUB, MODE_SBC, MODE_CP: begin
          ci = (op.mode == MODE_SBC) ? f[FLAG_C] : 1'b0;
          d9 = {1'b0, b} + {8'd0, ci};
          d5 = {1'b0, b[3:0]} + {4'd0, ci};
          r8 = a - b - {7'd0, ci};
          fo = '0;
          fo[FLAG_Z] = (r8 == 8'h00);
          fo[FLAG_N] = 1'b1;
          fo[FLAG_H] = ({1'b0, a[3:0]} < d5);
          fo[FLAG_C] = ({1'b0, a} < d9);
          if (op.mode == MODE_CP) wr = 1'b0;
        end
        MODE_AND: begin
          r8 = a & b;
          fo = '0;
          fo[FLAG_Z] = (r8 == 8'h00);
          fo[FLAG_H] = 1'b1;
        end
        MODE_XOR, MODE_OR: begin
          r8 = (op.mode == MODE_XOR) ? (a ^ b) : (a | b);
          fo = '0;
          fo[FLAG_Z] = (r8 == 8'h00);
        end
        MODE_INC: begin
          r8 = a + 8'd1;
          fo = '0;
          fo[FLAG_Z] = (r8 == 8'h00);
          fo[FLAG_H] = (a[3:0] == 4'hF);
          fo[FLAG_C] = f[FLAG_C];
        end
        MODE_DEC: begin
          r8 = a - 8'd1;
          fo = '0;
          fo[FLAG_Z] = (r8 == 8'h00);
          fo[FLAG_N] = 1'b1;
          fo[FLAG_H] = (a[3:0] == 4'h0);
          fo[FLAG_C] = f[FLAG_C];
        end
        MODE_RLC:  begin r8 = {a[6:0], a[7]};       co = a[7]; end
        MODE_RRC:  begin r8 = {a[0], a[7:1]};       co = a[0]; end
        MODE_RL:   begin r8 = {a[6:0], f[FLAG_C]};  co = a[7]; end
        MODE_RR:   begin r8 = {f[FLAG_C], a[7:1]};  co = a[0]; end
        MODE_SLA:  begin r8 = {a[6:0], 1'b0};       co = a[7]; end
        MODE_SRA:  begin r8 = {a[7], a[7:1]};       co = a[0]; end
        MODE_SWAP: begin r8 = {a[3:0], a[7:4]};     co = 1'b0; end
        MODE_SRL:  begin r8 = {1'b0, a[7:1]};       co = a[0]; end
        MODE_BIT: begin
          wr = 1'b0;
          fo[FLAG_Z] = ~a[op.bit_index];
          fo[FLAG_N] = 1'b0;
          fo[FLAG_H] = 1'b1;
        end
        MODE_RES: r8 = a & ~(8'h01 << op.bit_index);
        MODE_SET: r8 = a | (8'h01 << op.bit_index);
        MODE_DAA: begin
          neg = f[FLAG_N];
          adj = f[FLAG_C] ? DAA_ADJ_HI : 8'h00;
          if (f[FLAG_H] || (!neg && a[3:0] > DAA_MAX_DIG)) adj = adj | DAA_ADJ_LO;
          if (f[FLAG_C] || (!neg && a > DAA_MAX_BCD)) adj = adj | DAA_ADJ_HI;
          r8 = neg ? (a - adj) : (a + adj);
          fo = '0;
          fo[FLAG_Z] = (r8 == 8'h00);
          fo[FLAG_N] = neg;
          fo[FLAG_C] = ((adj & DAA_ADJ_HI) != 8'h00);
        end
        MODE_ADD16: begin
          wide = 1'b1;
          s17  = {1'b0, op.operand_a} + {1'b0, op.operand_b};
          s13  = {1'b0, op.operand_a[11:0]} + {1'b0, op.operand_b[11:0]};
          r16  = s17[15:0];
          fo   = '0;
          fo[FLAG_Z] = f[FLAG_Z];
          fo[FLAG_H] = s13[12];
          fo[FLAG_C] = s17[16];
        end
        MODE_INC16: begin wide = 1'b1; r16 = op.operand_a + 16'd1; end
        MODE_DEC16: begin wide = 1'b1; r16 = op.operand_a - 16'd1; end
        default: begin
          // spare codes do nothing and pass operand_a through
          wide = 1'b1;
          wr   = 1'b0;
        end
      endcase
      // rotate and shift flags; accumulator-form rotates force z low
      if (op.mode >= MODE_RLC && op.mode <= MODE_SRL) begin
        fo = '0;
        fo[FLAG_Z] = !(op.accum_form && op.mode <= MODE_RR) && (r8 == 8'h00);
        fo[FLAG_C] = co;
      end
      res.result       = wide ? r16 : {8'h00, r8};
      res.flags_out    = fo;
      res.write_result = wr;
      return res;
    endfunction

    function void note_op(alu_op_t op);
      expected_results.push_back(predict(op));
    endfunction

    function void check_res(alu_res_t got);
      alu_res_t want;
      if (expected_results.size() == 0) begin
        failures++;
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ALU error: result transfer with none outstanding: result=%h flags=%b wr=%b",
                   got.result, got.flags_out, got.write_result);
        return;
      end
      want = expected_results.pop_front();
      if (got.result !== want.result || got.flags_out !== want.flags_out ||
          got.write_result !== want.write_result) begin
        failures++;
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("ALU mismatch: result exp=%h got=%h flags exp=%b got=%b wr exp=%b got=%b",
                   want.result, got.result, want.flags_out, got.flags_out,
                   want.write_result, got.write_result);
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void close_out();
      if (expected_results.size() != 0) begin
        failures += expected_results.size();
        $display("ALU error: %0d results never arrived", expected_results.size());
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [4:0]  in_mode;
  logic [15:0] in_operand_a;
  logic [15:0] in_operand_b;
  logic [2:0]  in_bit_index;
  logic        in_accum_form;
  logic [3:0]  in_flags_in;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] out_result;
  logic [3:0]  out_flags_out;
  logic        out_write_result;

  alu_result_checker sb = new();

  handheld_cpu_alu_with_flags dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_operand_a     (in_operand_a),
    .in_operand_b     (in_operand_b),
    .in_bit_index     (in_bit_index),
    .in_accum_form    (in_accum_form),
    .in_flags_in      (in_flags_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result       (out_result),
    .out_flags_out    (out_flags_out),
    .out_write_result (out_write_result)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // reset, held low and then released
  initial begin
    rst_n = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic alu_op_t make_op(logic [4:0] mode, logic [15:0] a, logic [15:0] b,
                                      logic [2:0] bi, logic acc, logic [3:0] f);
    alu_op_t op;
    op.mode       = mode;
    op.operand_a  = a;
    op.operand_b  = b;
    op.bit_index  = bi;
    op.accum_form = acc;
    op.flags_in   = f;
    return op;
  endfunction

  // operand mix: fixed corner words, corner low bytes with random high bytes, or fully random
  function automatic logic [15:0] pick_operand();
    logic [7:0] hi;
    hi = 8'($urandom);
    case ($urandom_range(0, 11))
      0:  return 16'h0000;
      1:  return 16'hFFFF;
      2:  return 16'h0FFF;
      3:  return {hi, 8'h00};
      4:  return {hi, 8'hFF};
      5:  return {hi, 8'h0F};
      6:  return {hi, 8'h80};
      7:  return {hi, ($urandom_range(0, 1) == 1) ? 8'h99 : 8'h9A};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic alu_op_t random_op();
    logic [4:0] mode;
    if ($urandom_range(0, 19) == 0)
      mode = 5'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
    else
      mode = 5'($urandom_range(MODE_ADD, MODE_DEC16));
    return make_op(mode, pick_operand(), pick_operand(), 3'($urandom),
                   1'($urandom), 4'($urandom));
  endfunction

  // one input transfer: present at the falling edge, hold until taken
  task automatic send_op(input alu_op_t op);
    @(negedge clk);
    in_valid      = 1'b1;
    in_mode       = op.mode;
    in_operand_a  = op.operand_a;
    in_operand_b  = op.operand_b;
    in_bit_index  = op.bit_index;
    in_accum_form = op.accum_form;
    in_flags_in   = op.flags_in;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_op(op);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  // sender: bursts of random length with random gaps
  task automatic drive_ops(ref alu_op_t ops[$]);
    int idx;
    int burst;
    idx = 0;
    while (idx < ops.size()) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      for (int k = 0; k < burst && idx < ops.size(); k++) begin
        send_op(ops[idx]);
        idx++;
      end
      idle_cycles($urandom_range(0, 5));
    end
    idle_cycles(1);
  endtask

  // stimulus and end of run
  initial begin : stimulus
    alu_op_t op_list[$];
    in_valid      = 1'b0;
    in_mode       = MODE_ADD;
    in_operand_a  = '0;
    in_operand_b  = '0;
    in_bit_index  = '0;
    in_accum_form = 1'b0;
    in_flags_in   = '0;

    // directed corners, one or more per operation, plus a spare code
    op_list.push_back(make_op(MODE_ADD,   16'h12FF, 16'hA501, 3'd0, 1'b0, 4'h0));
    op_list.push_back(make_op(MODE_ADC,   16'h000F, 16'h0000, 3'd0, 1'b0, 4'h1));
    op_list.push_back(make_op(MODE_SUB,   16'hFF00, 16'h0001, 3'd0, 1'b0, 4'hF));
    op_list.push_back(make_op(MODE_SBC,   16'h0010, 16'h000F, 3'd0, 1'b0, 4'h1));
    op_list.push_back(make_op(MODE_AND,   16'h00F0, 16'h000F, 3'd0, 1'b0, 4'hF));
    op_list.push_back(make_op(MODE_XOR,   16'h3C5A, 16'hC35A, 3'd0, 1'b0, 4'h0));
    op_list.push_back(make_op(MODE_OR,    16'hFF00, 16'h0000, 3'd0, 1'b0, 4'hF));
    op_list.push_back(make_op(MODE_CP,    16'h0042, 16'h0042, 3'd0, 1'b0, 4'h0));
    op_list.push_back(make_op(MODE_INC,   16'h00FF, 16'hFFFF, 3'd0, 1'b0, 4'h1));
    op_list.push_back(make_op(MODE_DEC,   16'h0010, 16'h0000, 3'd0, 1'b0, 4'h0));
    op_list.push_back(make_op(MODE_RLC,   16'h0080, 16'h0000, 3'd0, 1'b1, 4'h0));
    op_list.push_back(make_op(MODE_RRC,   16'h0000, 16'h0000, 3'd0, 1'b1, 4'hF));
    op_list.push_back(make_op(MODE_RL,    16'h0080, 16'h0000, 3'd0, 1'b0, 4'h0));
    op_list.push_back(make_op(MODE_RR,    16'h0001, 16'h0000, 3'd0, 1'b0, 4'h1));
    op_list.push_back(make_op(MODE_SLA,   16'h0080, 16'h0000, 3'd0, 1'b1, 4'hE));
    op_list.push_back(make_op(MODE_SRA,   16'h0081, 16'h0000, 3'd0, 1'b1, 4'h0));
    op_list.push_back(make_op(MODE_SWAP,  16'h00F0, 16'h0000, 3'd0, 1'b1, 4'hF));
    op_list.push_back(make_op(MODE_SRL,   16'h0001, 16'h0000, 3'd0, 1'b0, 4'h0));
    op_list.push_back(make_op(MODE_BIT,   16'h007F, 16'h0000, 3'd7, 1'b0, 4'h5));
    op_list.push_back(make_op(MODE_RES,   16'h00FF, 16'h0000, 3'd0, 1'b0, 4'hA));
    op_list.push_back(make_op(MODE_SET,   16'h0000, 16'h0000, 3'd7, 1'b0, 4'h5));
    op_list.push_back(make_op(MODE_DAA,   16'h009A, 16'h0000, 3'd0, 1'b0, 4'h0));
    op_list.push_back(make_op(MODE_DAA,   16'h0000, 16'h0000, 3'd0, 1'b0, 4'h7));
    op_list.push_back(make_op(MODE_ADD16, 16'hFFFF, 16'h0001, 3'd0, 1'b0, 4'h8));
    op_list.push_back(make_op(MODE_INC16, 16'hFFFF, 16'h0000, 3'd0, 1'b0, 4'h3));
    op_list.push_back(make_op(MODE_DEC16, 16'h0000, 16'h0000, 3'd0, 1'b0, 4'hC));
    op_list.push_back(make_op(MODE_SPARE_HI, 16'hBEEF, 16'h1234, 3'd5, 1'b1, 4'h9));

    for (int i = 0; i < NUM_RANDOM_OPS; i++)
      op_list.push_back(random_op());

    wait (rst_n);
    drive_ops(op_list);

    // drain, then allow for the pipeline depth
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    sb.close_out();
    if (sb.failures == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // receiver: stall patterns in segments, with long hold-offs
  initial begin : receiver
    stall_kind_t kind;
    int          seg;
    int          len;
    int          period;
    out_stall = 1'b0;
    seg = 0;
    wait (rst_n);
    forever begin
      // long hold-off so the pipeline fills and the input side stalls
      if (seg == 2 || $urandom_range(0, 11) == 0) begin
        repeat ($urandom_range(40, 90)) begin
          @(negedge clk);
          out_stall = 1'b1;
        end
      end
      kind   = stall_kind_t'($urandom_range(0, 3));
      len    = $urandom_range(20, 80);
      period = $urandom_range(2, 5);
      for (int n = 0; n < len; n++) begin
        @(negedge clk);
        case (kind)
          STALL_NONE:  out_stall = 1'b0;
          STALL_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall = ($urandom_range(0, 9) < 7);
          default:     out_stall = ((n % period) == 0);
        endcase
      end
      seg++;
    end
  end

  // result monitor: check each output transfer
  initial begin : monitor
    alu_res_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.result       = out_result;
        got.flags_out    = out_flags_out;
        got.write_result = out_write_result;
        sb.check_res(got);
      end
    end
  end

endmodule
